[sv/odo_pkg.sv]
// ----------------------------------------------------------------------------
// odo_pkg
// Shared constants, register indexes and the CORDIC arctangent table for the
// differential-drive odometry core.
// ----------------------------------------------------------------------------
package odo_pkg;

    // configuration register indexes
    localparam logic REG_MM_PER_PULSE   = 1'b0;
    localparam logic REG_INV_WHEEL_BASE = 1'b1;

    localparam logic [31:0] MM_PER_PULSE_RST   = 32'd7561700;
    localparam logic [31:0] INV_WHEEL_BASE_RST = 32'd9336885;

    // serial multiplier: wide multiplicand, narrow serial multiplier
    localparam int MUL_A_W = 50;
    localparam int MUL_B_W = 34;
    localparam int MUL_P_W = MUL_A_W + MUL_B_W;

    // angle constants, Q.32 radians
    localparam logic [35:0] Q32_TWO_PI  = 36'd26986075409;
    localparam logic [35:0] Q32_PI      = 36'd13493037705;
    localparam logic [35:0] Q32_HALF_PI = 36'd6746518852;

    // 572.9578 in Q16.16 (radians to tenths of a degree)
    localparam logic signed [33:0] HEADING_K = 34'sd37549362;

    // CORDIC start value, reciprocal gain in Q.30
    localparam logic signed [33:0] CORDIC_X0 = 34'sd652032874;

    function automatic logic [31:0] atan_entry(input logic [4:0] i);
        logic [31:0] v;
        begin
            case (i)
                5'd0:  v = 32'd843314856;
                5'd1:  v = 32'd497837829;
                5'd2:  v = 32'd263043836;
                5'd3:  v = 32'd133525158;
                5'd4:  v = 32'd67021686;
                5'd5:  v = 32'd33543515;
                5'd6:  v = 32'd16775850;
                5'd7:  v = 32'd8388437;
                5'd8:  v = 32'd4194282;
                5'd9:  v = 32'd2097149;
                5'd31: v = 32'd0;
                default: v = (32'd1 << (5'd30 - i)) - 32'd1;
            endcase
            return v;
        end
    endfunction

endpackage

[sv/odo_mul.sv]
// ----------------------------------------------------------------------------
// odo_mul
// Bit-serial signed shift-add multiplier: one multiplier bit per cycle,
// lowest bit first, the top bit carrying negative weight.
// ----------------------------------------------------------------------------
module odo_mul
(
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 start,
    input  logic signed [odo_pkg::MUL_A_W-1:0]   a,
    input  logic signed [odo_pkg::MUL_B_W-1:0]   b,
    output logic                                 done,
    output logic signed [odo_pkg::MUL_P_W-1:0]   prod
);

    localparam int AW = odo_pkg::MUL_A_W;
    localparam int BW = odo_pkg::MUL_B_W;
    localparam int CW = $clog2(BW);

    logic                 busy_reg;
    logic                 done_reg;
    logic [CW-1:0]        cnt_reg;
    logic signed [AW-1:0] a_reg;
    logic [BW-1:0]        b_reg;
    logic signed [AW+1:0] acc_reg;
    logic [BW-1:0]        lo_reg;

    logic signed [AW+1:0] a_ext;
    logic signed [AW+1:0] addend;
    logic signed [AW+1:0] acc_next;
    logic                 last;

    assign last  = (cnt_reg == CW'(BW - 1));
    assign a_ext = {{2{a_reg[AW-1]}}, a_reg};

    always_comb
    begin
        if (b_reg[0])
            addend = last ? -a_ext : a_ext;
        else
            addend = '0;
        acc_next = acc_reg + addend;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= busy_reg && last && !start;
            if (start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= '0;
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg + 1'b1;
                if (last)
                    busy_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            a_reg   <= a;
            b_reg   <= b;
            acc_reg <= '0;
            lo_reg  <= '0;
        end
        else if (busy_reg)
        begin
            acc_reg <= acc_next >>> 1;
            lo_reg  <= {acc_next[0], lo_reg[BW-1:1]};
            b_reg   <= b_reg >> 1;
        end
    end

    assign done = done_reg;
    assign prod = {acc_reg[AW-1:0], lo_reg};

endmodule

[sv/odo_cordic.sv]
// ----------------------------------------------------------------------------
// odo_cordic
// Reduces a Q.32 radian angle modulo 2*pi one quotient bit per cycle, folds
// it into [-pi/2, pi/2] and runs iterative rotation-mode CORDIC for cos/sin.
// ----------------------------------------------------------------------------
module odo_cordic
#(
    parameter int CORDIC_STEPS = 16
)
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               start,
    input  logic signed [49:0] angle,
    output logic               valid,
    output logic signed [33:0] cos_val,
    output logic signed [33:0] sin_val
);

    localparam int SW = $clog2(CORDIC_STEPS + 1);

    typedef enum logic [1:0] {C_IDLE, C_RED, C_FOLD, C_ROT} phase_t;

    phase_t            phase_reg;
    logic [5:0]        cnt_reg;
    logic [SW-1:0]     step_reg;
    logic              valid_reg;
    logic              neg_reg;
    logic              flip_reg;
    logic [35:0]       rem_reg;
    logic [34:0]       sh_reg;
    logic signed [33:0] x_reg;
    logic signed [33:0] y_reg;
    logic signed [34:0] z_reg;
    logic signed [33:0] cos_reg;
    logic signed [33:0] sin_reg;

    logic [49:0]        mag;
    logic [35:0]        cand;
    logic signed [36:0] r0;
    logic signed [36:0] r1;
    logic signed [36:0] r2;
    logic               flip;
    logic signed [33:0] xs;
    logic signed [33:0] ys;
    logic signed [34:0] at;
    logic [4:0]         idx;

    assign mag  = angle[49] ? 50'(-angle) : angle;
    assign cand = {rem_reg[34:0], sh_reg[34]};

    // fold the remainder into the half-turn either side of zero, then into the quarter-turn
    always_comb
    begin
        if (neg_reg && (rem_reg != '0))
            r0 = $signed({1'b0, odo_pkg::Q32_TWO_PI}) - $signed({1'b0, rem_reg});
        else
            r0 = $signed({1'b0, rem_reg});
        if (r0 > $signed({1'b0, odo_pkg::Q32_PI}))
            r1 = r0 - $signed({1'b0, odo_pkg::Q32_TWO_PI});
        else
            r1 = r0;
        flip = 1'b0;
        r2   = r1;
        if (r1 > $signed({1'b0, odo_pkg::Q32_HALF_PI}))
        begin
            r2   = r1 - $signed({1'b0, odo_pkg::Q32_PI});
            flip = 1'b1;
        end
        else if (r1 < -$signed({1'b0, odo_pkg::Q32_HALF_PI}))
        begin
            r2   = r1 + $signed({1'b0, odo_pkg::Q32_PI});
            flip = 1'b1;
        end
    end

    assign idx = 5'(step_reg);
    assign xs  = x_reg >>> idx;
    assign ys  = y_reg >>> idx;
    assign at  = $signed({3'b000, odo_pkg::atan_entry(idx)});

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= C_IDLE;
            cnt_reg   <= '0;
            step_reg  <= '0;
            valid_reg <= 1'b0;
        end
        else
        begin
            case (phase_reg)
                C_IDLE:
                begin
                    if (start)
                    begin
                        phase_reg <= C_RED;
                        cnt_reg   <= '0;
                        valid_reg <= 1'b0;
                    end
                end
                C_RED:
                begin
                    cnt_reg <= cnt_reg + 1'b1;
                    if (cnt_reg == 6'd34)
                        phase_reg <= C_FOLD;
                end
                C_FOLD:
                begin
                    phase_reg <= C_ROT;
                    step_reg  <= '0;
                end
                C_ROT:
                begin
                    step_reg <= step_reg + 1'b1;
                    if (step_reg == SW'(CORDIC_STEPS - 1))
                    begin
                        phase_reg <= C_IDLE;
                        valid_reg <= 1'b1;
                    end
                end
                default: phase_reg <= C_IDLE;
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        case (phase_reg)
            C_IDLE:
            begin
                if (start)
                begin
                    neg_reg <= angle[49];
                    rem_reg <= {21'd0, mag[49:35]};
                    sh_reg  <= mag[34:0];
                end
            end
            C_RED:
            begin
                rem_reg <= (cand >= odo_pkg::Q32_TWO_PI) ? cand - odo_pkg::Q32_TWO_PI : cand;
                sh_reg  <= {sh_reg[33:0], 1'b0};
            end
            C_FOLD:
            begin
                flip_reg <= flip;
                z_reg    <= 35'(r2 >>> 2);
                x_reg    <= odo_pkg::CORDIC_X0;
                y_reg    <= '0;
            end
            C_ROT:
            begin
                if (!z_reg[34])
                begin
                    x_reg <= x_reg - ys;
                    y_reg <= y_reg + xs;
                    z_reg <= z_reg - at;
                end
                else
                begin
                    x_reg <= x_reg + ys;
                    y_reg <= y_reg - xs;
                    z_reg <= z_reg + at;
                end
                if (step_reg == SW'(CORDIC_STEPS - 1))
                begin
                    cos_reg <= flip_reg ? -(x_reg + (z_reg[34] ? ys : -ys))
                                        :  (x_reg + (z_reg[34] ? ys : -ys));
                    sin_reg <= flip_reg ? -(y_reg + (z_reg[34] ? -xs : xs))
                                        :  (y_reg + (z_reg[34] ? -xs : xs));
                end
            end
            default: ;
        endcase
    end

    assign valid   = valid_reg;
    assign cos_val = cos_reg;
    assign sin_val = sin_reg;

endmodule

[sv/diff_drive_odometry_core.sv]
// ----------------------------------------------------------------------------
// diff_drive_odometry_core
// Each sample runs three serial multiplies, then angle reduction and CORDIC that
//   hide the heading multiply, then two more multiplies, then a load of the
//   output register. A new sample is accepted only once the previous result
//   has been loaded into the output register.
// Reset: asynchronous, active low; clears sums, last counts and registers to
//   their defaults. A finished item waits in the output register.
// ----------------------------------------------------------------------------
module diff_drive_odometry_core
#(
    parameter int CORDIC_STEPS = 16
)
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         s_tvalid,
    output logic         s_tready,
    input  logic [31:0]  s_tdata,   // left_count[15:0], right_count[31:16]
    output logic         m_tvalid,
    input  logic         m_tready,
    output logic [143:0] m_tdata,   // x_total[47:0], y_total[95:48], heading_total[143:96]
    input  logic         cfg_we,
    input  logic [0:0]   cfg_addr,
    input  logic [31:0]  cfg_wdata
);

    localparam int AW = odo_pkg::MUL_A_W;
    localparam int BW = odo_pkg::MUL_B_W;
    localparam int PW = odo_pkg::MUL_P_W;

    typedef enum logic [3:0] {
        S_IDLE, S_SUM, S_DIFF, S_ANG, S_HEAD, S_CS, S_MX, S_MY, S_OUT
    } state_t;

    state_t               state_reg;
    logic [31:0]          mpp_reg;
    logic [31:0]          iwb_reg;
    logic [15:0]          last_left_reg;
    logic [15:0]          last_right_reg;
    logic [47:0]          x_acc_reg;
    logic [47:0]          y_acc_reg;
    logic [47:0]          h_acc_reg;
    logic                 m_valid_reg;
    logic [143:0]         m_data_reg;
    logic                 mul_start_reg;
    logic                 cs_start_reg;
    logic signed [AW-1:0] mul_a_reg;
    logic signed [BW-1:0] mul_b_reg;
    logic signed [17:0]   diff_reg;
    logic signed [32:0]   mean_reg;
    logic signed [49:0]   angle_reg;

    logic                 m_valid_next;
    logic                 mul_start_next;
    logic                 cs_start_next;
    logic                 out_load;

    logic                 mul_done;
    logic signed [PW-1:0] mul_prod;
    logic                 cs_valid;
    logic signed [33:0]   cos_val;
    logic signed [33:0]   sin_val;

    logic [15:0]          dl16;
    logic [15:0]          dr16;
    logic signed [17:0]   sum_w;
    logic signed [17:0]   diff_w;
    logic                 in_acc;
    logic signed [AW-1:0] mpp_ext;
    logic signed [AW-1:0] mean_ext;

    assign dl16     = s_tdata[15:0] - last_left_reg;
    assign dr16     = s_tdata[31:16] - last_right_reg;
    assign sum_w    = 18'($signed(dl16)) + 18'($signed(dr16));
    assign diff_w   = 18'($signed(dr16)) - 18'($signed(dl16));
    assign in_acc   = s_tvalid && s_tready;
    assign mpp_ext  = $signed({18'd0, mpp_reg});
    assign mean_ext = AW'(mean_reg);

    assign s_tready = (state_reg == S_IDLE);
    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_data_reg;

    always_comb
    begin
        out_load = (state_reg == S_OUT) && (!m_valid_reg || m_tready);
        if (out_load)
            m_valid_next = 1'b1;
        else if (m_tready)
            m_valid_next = 1'b0;
        else
            m_valid_next = m_valid_reg;
        mul_start_next = ((state_reg == S_IDLE) && in_acc)
                      || (((state_reg == S_SUM) || (state_reg == S_DIFF)
                        || (state_reg == S_ANG) || (state_reg == S_MX)) && mul_done)
                      || ((state_reg == S_CS) && cs_valid);
        cs_start_next  = (state_reg == S_ANG) && mul_done;
    end

    odo_mul u_mul
    (
        .clk   (clk),
        .rst_n (rst_n),
        .start (mul_start_reg),
        .a     (mul_a_reg),
        .b     (mul_b_reg),
        .done  (mul_done),
        .prod  (mul_prod)
    );

    odo_cordic #(.CORDIC_STEPS(CORDIC_STEPS)) u_cordic
    (
        .clk     (clk),
        .rst_n   (rst_n),
        .start   (cs_start_reg),
        .angle   (angle_reg),
        .valid   (cs_valid),
        .cos_val (cos_val),
        .sin_val (sin_val)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            mpp_reg        <= odo_pkg::MM_PER_PULSE_RST;
            iwb_reg        <= odo_pkg::INV_WHEEL_BASE_RST;
            last_left_reg  <= '0;
            last_right_reg <= '0;
            x_acc_reg      <= '0;
            y_acc_reg      <= '0;
            h_acc_reg      <= '0;
            m_valid_reg    <= 1'b0;
            mul_start_reg  <= 1'b0;
            cs_start_reg   <= 1'b0;
        end
        else
        begin
            mul_start_reg <= mul_start_next;
            cs_start_reg  <= cs_start_next;
            m_valid_reg   <= m_valid_next;
            if (cfg_we)
            begin
                case (cfg_addr)
                    odo_pkg::REG_MM_PER_PULSE:   mpp_reg <= cfg_wdata;
                    odo_pkg::REG_INV_WHEEL_BASE: iwb_reg <= cfg_wdata;
                    default: ;
                endcase
            end
            case (state_reg)
                S_IDLE:
                begin
                    if (in_acc)
                    begin
                        last_left_reg  <= s_tdata[15:0];
                        last_right_reg <= s_tdata[31:16];
                        state_reg      <= S_SUM;
                    end
                end
                S_SUM:
                    if (mul_done)
                        state_reg <= S_DIFF;
                S_DIFF:
                    if (mul_done)
                        state_reg <= S_ANG;
                S_ANG:
                    if (mul_done)
                        state_reg <= S_HEAD;
                S_HEAD:
                    if (mul_done)
                    begin
                        h_acc_reg <= h_acc_reg + mul_prod[79:32];
                        state_reg <= S_CS;
                    end
                S_CS:
                    if (cs_valid)
                        state_reg <= S_MX;
                S_MX:
                    if (mul_done)
                    begin
                        x_acc_reg <= x_acc_reg + mul_prod[77:30];
                        state_reg <= S_MY;
                    end
                S_MY:
                    if (mul_done)
                    begin
                        y_acc_reg <= y_acc_reg + mul_prod[77:30];
                        state_reg <= S_OUT;
                    end
                S_OUT:
                    if (out_load)
                        state_reg <= S_IDLE;
                default: state_reg <= S_IDLE;
            endcase
        end
    end

    // operands and intermediate values
    always_ff @(posedge clk)
    begin
        case (state_reg)
            S_IDLE:
                if (in_acc)
                begin
                    diff_reg  <= diff_w;
                    mul_a_reg <= mpp_ext;
                    mul_b_reg <= BW'(sum_w);
                end
            S_SUM:
                if (mul_done)
                begin
                    mean_reg  <= mul_prod[49:17];
                    mul_a_reg <= mpp_ext;
                    mul_b_reg <= BW'(diff_reg);
                end
            S_DIFF:
                if (mul_done)
                begin
                    mul_a_reg <= AW'($signed(mul_prod[49:16]));
                    mul_b_reg <= $signed({2'b00, iwb_reg});
                end
            S_ANG:
                if (mul_done)
                begin
                    angle_reg <= mul_prod[65:16];
                    mul_a_reg <= mul_prod[65:16];
                    mul_b_reg <= odo_pkg::HEADING_K;
                end
            S_CS:
                if (cs_valid)
                begin
                    mul_a_reg <= mean_ext;
                    mul_b_reg <= cos_val;
                end
            S_MX:
                if (mul_done)
                begin
                    mul_a_reg <= mean_ext;
                    mul_b_reg <= -sin_val;
                end
            S_OUT:
                if (out_load)
                    m_data_reg <= {h_acc_reg, y_acc_reg, x_acc_reg};
            default: ;
        endcase
    end

    a_accept_leaves_idle: assert property (@(posedge clk) disable iff (!rst_n)
        in_acc |=> (state_reg == S_SUM))
        else $error("accepted item did not start the sequence");

    a_no_start_on_done: assert property (@(posedge clk) disable iff (!rst_n)
        mul_done |-> !mul_start_reg)
        else $error("multiplier restarted while finishing");

    a_cs_ready_for_x: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_MX) |-> cs_valid)
        else $error("x step began before cos/sin were ready");

    a_out_from_seq: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(m_valid_reg) |-> $past(state_reg == S_OUT))
        else $error("result shown outside the output step");

endmodule

[test/diff_drive_odometry_core_chk.sv]
// ----------------------------------------------------------------------------
// diff_drive_odometry_core_chk
// Watches the sample, pose and register channels of the odometry core. It
// keeps its own copy of the pose sums and predicts each pose item in fixed
// point, then compares every pose item that leaves the core with the oldest
// prediction.
// ----------------------------------------------------------------------------
module diff_drive_odometry_core_chk
#(
    parameter int CORDIC_STEPS = 16
)
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         s_tvalid,
    input  logic         s_tready,
    input  logic [31:0]  s_tdata,   // left_count[15:0], right_count[31:16]
    input  logic         m_tvalid,
    input  logic         m_tready,
    input  logic [143:0] m_tdata,   // x_total[47:0], y_total[95:48], heading_total[143:96]
    input  logic         cfg_we,
    input  logic [0:0]   cfg_addr,
    input  logic [31:0]  cfg_wdata,
    output int           mismatches,
    output int           outstanding
);

    typedef struct packed {
        logic [47:0] x;
        logic [47:0] y;
        logic [47:0] heading;
    } pose_t;

    localparam longint TWO_PI_Q32  = 64'sd26986075409;
    localparam longint PI_Q32      = 64'sd13493037705;
    localparam longint HALF_PI_Q32 = 64'sd6746518852;
    localparam longint DECIDEG_K   = 64'sd37549362;
    localparam longint GAIN_X0     = 64'sd652032874;
    localparam longint ATAN_HEAD [10] = '{
        64'sd843314856, 64'sd497837829, 64'sd263043836, 64'sd133525158, 64'sd67021686,
        64'sd33543515, 64'sd16775850, 64'sd8388437, 64'sd4194282, 64'sd2097149
    };

    logic [15:0] prev_left, prev_right;
    logic [47:0] x_sum, y_sum, heading_sum;
    logic [31:0] mm_per_pulse, inv_wheel_base;
    pose_t       expected_poses [$];

    // advances the predicted pose by one encoder sample
    function automatic pose_t odometry_advance(input logic [15:0] l, input logic [15:0] r);
        longint dl, dr, pl, pr, mean, dq, angle, a_hi, a_lo, head;
        longint rr, cx, cy, z, xs, ys, step;
        bit     fold;
        pose_t  p;
        dl = longint'($signed(l - prev_left));
        dr = longint'($signed(r - prev_right));
        pl = dl * longint'(mm_per_pulse);
        pr = dr * longint'(mm_per_pulse);
        mean = (pl + pr) >>> 17;
        dq = (pr - pl) >>> 16;
        angle = dq * longint'(inv_wheel_base[31:16])
              + ((dq * longint'(inv_wheel_base[15:0])) >>> 16);
        a_hi = angle >>> 16;
        a_lo = angle - a_hi * 65536;
        head = (a_hi * DECIDEG_K + ((a_lo * DECIDEG_K) >>> 16)) >>> 16;
        // reduce into (-pi, pi], then fold into [-pi/2, pi/2]
        rr = angle % TWO_PI_Q32;
        if (rr < 0)
            rr += TWO_PI_Q32;
        if (rr > PI_Q32)
            rr -= TWO_PI_Q32;
        fold = 1'b0;
        if (rr > HALF_PI_Q32)
        begin
            rr -= PI_Q32;
            fold = 1'b1;
        end
        else if (rr < -HALF_PI_Q32)
        begin
            rr += PI_Q32;
            fold = 1'b1;
        end
        z = rr >>> 2;
        cx = GAIN_X0;
        cy = 0;
        for (int i = 0; i < CORDIC_STEPS && i < 32; i++)
        begin
            if (i < 10)
                step = ATAN_HEAD[i];
            else if (i > 30)
                step = 0;
            else
                step = (64'sd1 <<< (30 - i)) - 1;
            xs = cx >>> i;
            ys = cy >>> i;
            if (z >= 0)
            begin
                cx -= ys;
                cy += xs;
                z -= step;
            end
            else
            begin
                cx += ys;
                cy -= xs;
                z += step;
            end
        end
        if (fold)
        begin
            cx = -cx;
            cy = -cy;
        end
        xs = (cx * mean) >>> 30;
        ys = (-(cy * mean)) >>> 30;
        x_sum = x_sum + xs[47:0];
        y_sum = y_sum + ys[47:0];
        heading_sum = heading_sum + head[47:0];
        prev_left = l;
        prev_right = r;
        p.x = x_sum;
        p.y = y_sum;
        p.heading = heading_sum;
        return p;
    endfunction

    task automatic note_mismatch(input string what, input logic [47:0] exp_v,
                                 input logic [47:0] act_v);
        mismatches++;
        if (mismatches <= 10)
            $display("mismatch %s: expected %0d got %0d", what,
                     $signed(exp_v), $signed(act_v));
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        pose_t want, got;
        if (!rst_n)
        begin
            prev_left = '0;
            prev_right = '0;
            x_sum = '0;
            y_sum = '0;
            heading_sum = '0;
            mm_per_pulse = odo_pkg::MM_PER_PULSE_RST;
            inv_wheel_base = odo_pkg::INV_WHEEL_BASE_RST;
            expected_poses.delete();
            mismatches = 0;
            outstanding <= 0;
        end
        else
        begin
            if (m_tvalid && m_tready)
            begin
                got.x = m_tdata[47:0];
                got.y = m_tdata[95:48];
                got.heading = m_tdata[143:96];
                if (expected_poses.size() == 0)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("mismatch: pose item with nothing expected");
                end
                else
                begin
                    want = expected_poses.pop_front();
                    if (want.x !== got.x)
                        note_mismatch("x_total", want.x, got.x);
                    if (want.y !== got.y)
                        note_mismatch("y_total", want.y, got.y);
                    if (want.heading !== got.heading)
                        note_mismatch("heading_total", want.heading, got.heading);
                end
            end
            if (s_tvalid && s_tready)
                expected_poses.push_back(odometry_advance(s_tdata[15:0], s_tdata[31:16]));
            if (cfg_we)
            begin
                if (cfg_addr == odo_pkg::REG_MM_PER_PULSE)
                    mm_per_pulse = cfg_wdata;
                else if (cfg_addr == odo_pkg::REG_INV_WHEEL_BASE)
                    inv_wheel_base = cfg_wdata;
            end
            outstanding <= expected_poses.size();
        end
    end

endmodule

[test/diff_drive_odometry_core_tb.sv]
// ----------------------------------------------------------------------------
// diff_drive_odometry_core_tb
// Drives encoder samples and register writes into the odometry core under
// random back-pressure; a separate checker predicts and compares every pose.
// ----------------------------------------------------------------------------
module diff_drive_odometry_core_tb;

    localparam int LIMIT = 4000000;

    logic         clk;
    logic         rst_n;
    logic         s_tvalid;
    logic         s_tready;
    logic [31:0]  s_tdata;
    logic         m_tvalid;
    logic         m_tready;
    logic [143:0] m_tdata;
    logic         cfg_we;
    logic [0:0]   cfg_addr;
    logic [31:0]  cfg_wdata;

    int          mismatches;
    int          outstanding;
    int          cycles = 0;
    int          src_idle_pct;
    int          snk_idle_pct;
    logic [15:0] sent_left, sent_right;

    diff_drive_odometry_core dut (
        .clk(clk), .rst_n(rst_n),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
        .cfg_we(cfg_we), .cfg_addr(cfg_addr), .cfg_wdata(cfg_wdata)
    );

    diff_drive_odometry_core_chk chk (
        .clk(clk), .rst_n(rst_n),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
        .cfg_we(cfg_we), .cfg_addr(cfg_addr), .cfg_wdata(cfg_wdata),
        .mismatches(mismatches), .outstanding(outstanding)
    );

    always
    begin
        clk = 1'b1;
        #1;
        clk = 1'b0;
        #1;
    end

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles > LIMIT)
        begin
            $display("diff_drive_odometry_core regression: fail");
            $finish;
        end
    end

    always @(posedge clk)
    begin
        if (rst_n)
            m_tready <= ($urandom_range(99) >= snk_idle_pct);
        else
            m_tready <= 1'b0;
    end

    task automatic send_sample(input logic [15:0] l, input logic [15:0] r);
        if ($urandom_range(99) < src_idle_pct)
        begin
            s_tvalid <= 1'b0;
            @(posedge clk);
            while ($urandom_range(99) < src_idle_pct)
                @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata <= {r, l};
        sent_left = l;
        sent_right = r;
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
    endtask

    task automatic wait_drained();
        s_tvalid <= 1'b0;
        @(posedge clk);
        while (outstanding != 0)
            @(posedge clk);
        repeat (300) @(posedge clk);
    endtask

    task automatic write_regs(input logic [31:0] mpp, input logic [31:0] iwb);
        cfg_we <= 1'b1;
        cfg_addr <= odo_pkg::REG_MM_PER_PULSE;
        cfg_wdata <= mpp;
        @(posedge clk);
        cfg_addr <= odo_pkg::REG_INV_WHEEL_BASE;
        cfg_wdata <= iwb;
        @(posedge clk);
        cfg_we <= 1'b0;
    endtask

    task automatic send_step(input int dl, input int dr);
        send_sample(sent_left + dl[15:0], sent_right + dr[15:0]);
    endtask

    initial
    begin
        int kind;
        rst_n = 1'b0;
        s_tvalid = 1'b0;
        s_tdata = '0;
        cfg_we = 1'b0;
        cfg_addr = odo_pkg::REG_MM_PER_PULSE;
        cfg_wdata = '0;
        src_idle_pct = 10;
        snk_idle_pct = 66;
        sent_left = '0;
        sent_right = '0;
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed: straight, turns, counter wrap both ways, full-range counts
        send_step(0, 0);
        send_step(1000, 1000);
        send_step(500, -100);
        send_step(-700, 700);
        send_step(32767, -32768);
        send_step(32768, 32768);
        send_step(-1, 1);
        send_sample(16'hFFFF, 16'hFFFF);
        send_sample(16'h0000, 16'h0000);
        send_sample(16'hFFFF, 16'h0000);
        wait_drained();
        // largest registers: angles far beyond a full turn
        write_regs(32'hFFFF_FFFF, 32'hFFFF_FFFF);
        send_step(32767, -32768);
        send_step(-32768, 32767);
        send_step(12000, -9000);
        send_step(3, 5);
        send_step(100, 100);
        wait_drained();
        write_regs(32'h0000_0000, 32'h0000_0000);
        send_step(32767, -32768);
        send_step(-500, 200);
        wait_drained();
        write_regs(32'h8000_0000, 32'h0000_0001);
        send_step(-32768, 32767);
        send_step(40, -40);
        wait_drained();

        for (int phase = 0; phase < 5; phase++)
        begin
            src_idle_pct = (phase < 2) ? 10 : (phase < 4) ? 66 : 0;
            snk_idle_pct = (phase < 2) ? 66 : (phase < 4) ? 10 : 0;
            case (phase)
                0: write_regs(odo_pkg::MM_PER_PULSE_RST, odo_pkg::INV_WHEEL_BASE_RST);
                1: write_regs($urandom, $urandom);
                2: write_regs($urandom_range(32'h00FF_FFFF), $urandom);
                3: write_regs($urandom, $urandom_range(32'h0FFF_FFFF));
                default: write_regs(odo_pkg::MM_PER_PULSE_RST, odo_pkg::INV_WHEEL_BASE_RST);
            endcase
            for (int n = 0; n < 246; n++)
            begin
                kind = $urandom_range(99);
                if (kind < 75)
                    send_step($urandom_range(400) - 200, $urandom_range(400) - 200);
                else if (kind < 88)
                    send_step($urandom_range(65535) - 32768, $urandom_range(65535) - 32768);
                else
                    send_sample($urandom, $urandom);
            end
            wait_drained();
        end

        if (mismatches == 0 && outstanding == 0)
            $display("diff_drive_odometry_core regression: pass");
        else
            $display("diff_drive_odometry_core regression: fail");
        $finish;
    end

endmodule

[diff_drive_odometry_core.f]
sv/odo_pkg.sv
sv/odo_mul.sv
sv/odo_cordic.sv
sv/diff_drive_odometry_core.sv
test/diff_drive_odometry_core_chk.sv
test/diff_drive_odometry_core_tb.sv
